[sv/btl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btl_pkg
// types, codes and the microcode table of the bakery ticket lock sequencer
// ----------------------------------------------------------------------------
package btl_pkg;

	localparam int THREAD_ID_W  = 3;
	localparam int ID_SPACE     = 1 << THREAD_ID_W;
	localparam int CFG_W        = 4;
	localparam int OUT_TICKET_W = 16;
	localparam int STEP_W       = 4;

	typedef enum logic [1:0] {
		MODE_TAKE    = 2'd0,
		MODE_POLL    = 2'd1,
		MODE_RELEASE = 2'd2,
		MODE_NOP     = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_THREAD = 2'd1,
		ST_OVERFLOW   = 2'd2,
		ST_NO_TICKET  = 2'd3
	} status_t;

	// sequencer steps, in program order
	typedef enum logic [STEP_W-1:0] {
		STEP_FETCH    = 4'd0,
		STEP_DECODE   = 4'd1,
		STEP_MAX_SCAN = 4'd2,
		STEP_TAKE_WB  = 4'd3,
		STEP_ORD_SCAN = 4'd4,
		STEP_POLL_RES = 4'd5,
		STEP_REL_WB   = 4'd6,
		STEP_NOP_RES  = 4'd7,
		STEP_BAD_RES  = 4'd8,
		STEP_PUSH     = 4'd9
	} step_t;

	typedef enum logic {
		ADDR_ID   = 1'b0,
		ADDR_SCAN = 1'b1
	} addr_sel_t;

	typedef enum logic [1:0] {
		SCAN_NONE = 2'd0,
		SCAN_MAX  = 2'd1,
		SCAN_ORD  = 2'd2
	} scan_op_t;

	typedef enum logic [1:0] {
		WR_NONE  = 2'd0,
		WR_TAKE  = 2'd1,
		WR_CLEAR = 2'd2
	} wr_op_t;

	typedef enum logic [2:0] {
		RES_NONE = 3'd0,
		RES_TAKE = 3'd1,
		RES_POLL = 3'd2,
		RES_ZERO = 3'd3,
		RES_OWN  = 3'd4,
		RES_BAD  = 3'd5
	} res_op_t;

	typedef enum logic [2:0] {
		JC_NEVER     = 3'd0,
		JC_ALWAYS    = 3'd1,
		JC_NO_ACCEPT = 3'd2,
		JC_MORE      = 3'd3,
		JC_DISPATCH  = 3'd4
	} jump_cond_t;

	typedef struct packed {
		addr_sel_t  addr_sel;
		logic       ld_own;
		logic       clr_scan;
		scan_op_t   scan_op;
		wr_op_t     wr_op;
		res_op_t    res_op;
		logic       push;
		logic       hold;
		jump_cond_t jc;
		step_t      target;
	} uc_word_t;

	localparam uc_word_t UC_NOP = '{
		addr_sel: ADDR_ID, ld_own: 1'b0, clr_scan: 1'b0, scan_op: SCAN_NONE,
		wr_op: WR_NONE, res_op: RES_NONE, push: 1'b0, hold: 1'b0,
		jc: JC_NEVER, target: STEP_FETCH
	};

	// control store
	function automatic uc_word_t uc_rom(input step_t pc);
		uc_word_t w;
		w = UC_NOP;
		case (pc)
			STEP_FETCH: begin
				w.jc     = JC_NO_ACCEPT;
				w.target = STEP_FETCH;
			end
			STEP_DECODE: begin
				w.ld_own   = 1'b1;
				w.clr_scan = 1'b1;
				w.jc       = JC_DISPATCH;
			end
			STEP_MAX_SCAN: begin
				w.addr_sel = ADDR_SCAN;
				w.scan_op  = SCAN_MAX;
				w.jc       = JC_MORE;
				w.target   = STEP_MAX_SCAN;
			end
			STEP_TAKE_WB: begin
				w.wr_op  = WR_TAKE;
				w.res_op = RES_TAKE;
				w.jc     = JC_ALWAYS;
				w.target = STEP_PUSH;
			end
			STEP_ORD_SCAN: begin
				w.addr_sel = ADDR_SCAN;
				w.scan_op  = SCAN_ORD;
				w.jc       = JC_MORE;
				w.target   = STEP_ORD_SCAN;
			end
			STEP_POLL_RES: begin
				w.res_op = RES_POLL;
				w.jc     = JC_ALWAYS;
				w.target = STEP_PUSH;
			end
			STEP_REL_WB: begin
				w.wr_op  = WR_CLEAR;
				w.res_op = RES_ZERO;
				w.jc     = JC_ALWAYS;
				w.target = STEP_PUSH;
			end
			STEP_NOP_RES: begin
				w.res_op = RES_OWN;
				w.jc     = JC_ALWAYS;
				w.target = STEP_PUSH;
			end
			STEP_BAD_RES: begin
				w.res_op = RES_BAD;
			end
			STEP_PUSH: begin
				w.push   = 1'b1;
				w.hold   = 1'b1;
				w.jc     = JC_ALWAYS;
				w.target = STEP_FETCH;
			end
			default: begin
				w.jc     = JC_ALWAYS;
				w.target = STEP_FETCH;
			end
		endcase
		return w;
	endfunction

	// multiway branch at decode
	function automatic step_t dispatch_target(input logic bad, input mode_t mode);
		step_t t;
		if (bad) begin
			t = STEP_BAD_RES;
		end else begin
			case (mode)
				MODE_TAKE:    t = STEP_MAX_SCAN;
				MODE_POLL:    t = STEP_ORD_SCAN;
				MODE_RELEASE: t = STEP_REL_WB;
				default:      t = STEP_NOP_RES;
			endcase
		end
		return t;
	endfunction

endpackage

[sv/bakery_ticket_lock_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bakery_ticket_lock_core
// bakery (ticket order) lock arbiter run by a small microcoded sequencer
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+--------------------------------
//  request  | in        | in_valid / in_stall | mode, thread_id
//  result   | out       | out_valid/out_stall | ticket, granted, status
//  config   | in        | cfg_we              | cfg_wdata (threads_in_use)
//
//  a take or poll beat scans n entries of the ticket table, n being the
//  scanned thread count (8 at reset); release, bad thread and mode 3 skip the scan
//  the scan goes through the single read port of the ticket table, which the
//  scan loop walks one entry per cycle
//  result beats sit in an output register, so a new request is taken while the
//  previous result is still stalled; only a second result waits for the slot
//  arst_n clears the ticket table, the sequencer and the output valid flag
// ----------------------------------------------------------------------------
module bakery_ticket_lock_core #(
	parameter int MAX_THREADS = 8,
	parameter int TICKET_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration
	input  logic                                  cfg_we,
	input  logic [btl_pkg::CFG_W-1:0]             cfg_wdata,
	// request beats
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  btl_pkg::mode_t                        mode,
	input  logic [btl_pkg::THREAD_ID_W-1:0]       thread_id,
	// result beats
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [btl_pkg::OUT_TICKET_W-1:0]      ticket,
	output logic                                  granted,
	output btl_pkg::status_t                      status
);

	import btl_pkg::*;

	// thread ids above the id space can never be written, so their entries
	// stay zero and add nothing to a scan: the table stops at the id space
	localparam int TBL_DEPTH = (MAX_THREADS < ID_SPACE) ? MAX_THREADS : ID_SPACE;
	localparam int IDX_W     = $clog2(TBL_DEPTH);
	localparam logic [CFG_W-1:0] TBL_CNT = CFG_W'(TBL_DEPTH);
	localparam logic [CFG_W-1:0] CFG_RST = CFG_W'(8);

	// configuration register
	logic [CFG_W-1:0]        threads_q;

	// sequencer
	step_t                   pc_q;
	step_t                   pc_nxt;
	uc_word_t                uc;
	logic                    jump_taken;
	step_t                   jump_target;

	// request latched at accept
	mode_t                   mode_q;
	logic [IDX_W-1:0]        id_q;
	logic                    bad_q;
	logic [IDX_W-1:0]        last_q;

	// datapath
	logic [TICKET_BITS-1:0]  tbl_q [TBL_DEPTH];
	logic [IDX_W-1:0]        rd_addr;
	logic [TICKET_BITS-1:0]  rd_data;
	logic [IDX_W-1:0]        j_q;
	logic [TICKET_BITS-1:0]  own_q;
	logic [TICKET_BITS-1:0]  acc_q;
	logic                    gnt_q;
	logic [TICKET_BITS-1:0]  next_ticket;
	logic                    at_max;
	logic                    beats_me;

	// staged result and the output slot
	logic [TICKET_BITS-1:0]  res_ticket_q;
	logic                    res_gnt_q;
	status_t                 res_status_q;
	logic [TICKET_BITS+OUT_TICKET_W-1:0] res_ext;
	logic                    out_valid_q;
	logic                    out_busy;
	logic                    in_accept;

	// thread count seen at accept
	logic [CFG_W-1:0]        n_clamp;
	logic [CFG_W-1:0]        n_eff;

	assign in_stall  = (pc_q != STEP_FETCH);
	assign in_accept = in_valid && !in_stall;
	assign out_busy  = out_valid_q && out_stall;
	assign out_valid = out_valid_q;

	// a zero count acts as one, anything past the table acts as the table
	always_comb begin
		n_clamp = (threads_q == '0) ? CFG_W'(1) : threads_q;
		n_eff   = (n_clamp > TBL_CNT) ? TBL_CNT : n_clamp;
	end

	// ------------------------------------------------------------------------
	// control: fetch the word, then pick the next step
	// ------------------------------------------------------------------------
	always_comb begin
		uc = uc_rom(pc_q);
	end

	always_comb begin
		jump_target = uc.target;
		case (uc.jc)
			JC_NEVER:     jump_taken = 1'b0;
			JC_ALWAYS:    jump_taken = 1'b1;
			JC_NO_ACCEPT: jump_taken = !in_accept;
			JC_MORE:      jump_taken = (j_q != last_q);
			JC_DISPATCH: begin
				jump_taken  = 1'b1;
				jump_target = dispatch_target(bad_q, mode_q);
			end
			default:      jump_taken = 1'b0;
		endcase
	end

	always_comb begin
		if (uc.hold && out_busy) begin
			pc_nxt = pc_q;
		end else if (jump_taken) begin
			pc_nxt = jump_target;
		end else begin
			pc_nxt = step_t'(pc_q + STEP_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_FETCH;
		end else begin
			pc_q <= pc_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threads_q <= CFG_RST;
		end else if (cfg_we) begin
			threads_q <= cfg_wdata;
		end
	end

	// ------------------------------------------------------------------------
	// datapath
	// ------------------------------------------------------------------------
	// one read port, shared by the own-ticket fetch and the scan
	assign rd_addr = (uc.addr_sel == ADDR_SCAN) ? j_q : id_q;
	assign rd_data = tbl_q[rd_addr];

	assign at_max      = (acc_q == '1);
	assign next_ticket = acc_q + TICKET_BITS'(1);

	// another live ticket ahead of ours in (ticket, thread id) order
	assign beats_me = (j_q != id_q) && (rd_data != '0) &&
	                  ((rd_data < own_q) || ((rd_data == own_q) && (j_q < id_q)));

	// ticket table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TBL_DEPTH; k++) begin
				tbl_q[k] <= '0;
			end
		end else begin
			case (uc.wr_op)
				WR_TAKE: begin
					if (!at_max) begin
						tbl_q[id_q] <= next_ticket;
					end
				end
				WR_CLEAR: tbl_q[id_q] <= '0;
				default: ;
			endcase
		end
	end

	// request capture, scan registers and result staging
	always_ff @(posedge clk) begin
		if (in_accept) begin
			mode_q <= mode;
			id_q   <= thread_id[IDX_W-1:0];
			bad_q  <= (CFG_W'(thread_id) >= n_eff);
			last_q <= IDX_W'(n_eff - CFG_W'(1));
		end

		if (uc.ld_own) begin
			own_q <= rd_data;
		end

		if (uc.clr_scan) begin
			j_q   <= '0;
			acc_q <= '0;
			gnt_q <= 1'b1;
		end else begin
			case (uc.scan_op)
				SCAN_MAX: begin
					j_q <= j_q + IDX_W'(1);
					if (rd_data > acc_q) begin
						acc_q <= rd_data;
					end
				end
				SCAN_ORD: begin
					j_q <= j_q + IDX_W'(1);
					if (beats_me) begin
						gnt_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end

		case (uc.res_op)
			RES_TAKE: begin
				res_gnt_q <= 1'b0;
				if (at_max) begin
					res_ticket_q <= own_q;
					res_status_q <= ST_OVERFLOW;
				end else begin
					res_ticket_q <= next_ticket;
					res_status_q <= ST_OK;
				end
			end
			RES_POLL: begin
				if (own_q == '0) begin
					res_ticket_q <= '0;
					res_gnt_q    <= 1'b0;
					res_status_q <= ST_NO_TICKET;
				end else begin
					res_ticket_q <= own_q;
					res_gnt_q    <= gnt_q;
					res_status_q <= ST_OK;
				end
			end
			RES_ZERO: begin
				res_ticket_q <= '0;
				res_gnt_q    <= 1'b0;
				res_status_q <= ST_OK;
			end
			RES_OWN: begin
				res_ticket_q <= own_q;
				res_gnt_q    <= 1'b0;
				res_status_q <= ST_OK;
			end
			RES_BAD: begin
				res_ticket_q <= '0;
				res_gnt_q    <= 1'b0;
				res_status_q <= ST_BAD_THREAD;
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------------
	// output slot
	// ------------------------------------------------------------------------
	// low 16 bits of the entry, zero filled for narrow tickets
	assign res_ext = {{OUT_TICKET_W{1'b0}}, res_ticket_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (uc.push && !out_busy) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uc.push && !out_busy) begin
			ticket  <= res_ext[OUT_TICKET_W-1:0];
			granted <= res_gnt_q;
			status  <= res_status_q;
		end
	end

endmodule
